>>> hw/rtl/hrf_pkg.sv
// Shared types, constants and the keyword table of the HTTP request framer.
// No dependencies; every other file of the block imports this package.
package hrf_pkg;

  localparam int FIELD_W       = 21;
  localparam int MAX_BYTES_DEF = 1048576;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int KEY_LEN       = 15;
  localparam int KEY_W         = 4;

  localparam logic [FIELD_W-1:0] MAX_SIZE_RST = 21'd1048576;

  // Register indexes of the configuration port (index = paddr[2]).
  localparam logic REG_MAX_SIZE = 1'b0;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;

  // Phases of the Content-Length value parser.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_LEAD  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  // Progress through CR LF CR LF.
  localparam logic [1:0] BL_NONE  = 2'd0;
  localparam logic [1:0] BL_CR    = 2'd1;
  localparam logic [1:0] BL_CRLF  = 2'd2;
  localparam logic [1:0] BL_CRLFCR = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5a;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] header_length;
    logic [FIELD_W-1:0] body_length;
  } hrf_res_t;

  // Lower-case text of "content-length:", one character per position.
  function automatic logic [7:0] key_char(input logic [KEY_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h6c; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3a; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/hrf_in_reg.sv
// Input register of the HTTP request framer: holds one byte for the parser.
// Depends on hrf_pkg.
module hrf_in_reg
  import hrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  assign in_ready     = !s1_valid_r || advance;
  assign s1_valid_nxt = (in_valid && in_ready) || (s1_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

>>> hw/rtl/hrf_core.sv
// Framing state and next-state logic of the HTTP request framer.
// Depends on hrf_pkg.
module hrf_core
  import hrf_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [7:0]         data,
  input  logic [FIELD_W-1:0] max_size,
  output logic               res_valid,
  output hrf_res_t           res
);

  localparam int VAL_W = $clog2(MAX_BYTES + 1);
  localparam int NV_W  = VAL_W + 4;
  localparam int SUM_W = ((VAL_W > FIELD_W) ? VAL_W : FIELD_W) + 1;
  localparam logic [NV_W-1:0] MAX_NV = NV_W'(MAX_BYTES);

  logic [FIELD_W-1:0] byte_count_r, byte_count_nxt;
  logic [1:0]         blank_r, blank_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic               found_r, found_nxt;
  logic [VAL_W-1:0]   value_r, value_nxt;
  logic               saw_cr_r, saw_cr_nxt;
  logic               hdr_done_r, hdr_done_nxt;
  logic [FIELD_W-1:0] hdr_bytes_r, hdr_bytes_nxt;
  logic [VAL_W-1:0]   body_rem_r, body_rem_nxt;

  logic [FIELD_W-1:0] lim;
  logic [FIELD_W:0]   cnt_inc;
  logic [7:0]         lc;
  logic               is_digit;
  logic [NV_W-1:0]    nv;
  logic [VAL_W-1:0]   rem_dec;
  logic [SUM_W-1:0]   total;
  logic               bad;
  logic               clear;

  // Effective size limit is the register clamped to the build-time maximum.
  assign lim = (32'(max_size) > 32'(MAX_BYTES)) ? FIELD_W'(MAX_BYTES) : max_size;

  assign cnt_inc  = {1'b0, byte_count_r} + {{FIELD_W{1'b0}}, 1'b1};
  assign lc       = (data >= CH_UPA && data <= CH_UPZ) ? (data | 8'h20) : data;
  assign is_digit = (data >= CH_ZERO) && (data <= CH_NINE);
  // value * 10 + digit, as two shifts and two adds.
  assign nv = ({4'b0, value_r} << 3) + ({4'b0, value_r} << 1) + NV_W'(data[3:0]);
  assign rem_dec = body_rem_r - VAL_W'(body_rem_r != '0);
  assign total   = SUM_W'(cnt_inc[FIELD_W-1:0]) + SUM_W'(value_r);

  always_comb begin
    byte_count_nxt = byte_count_r;
    blank_nxt      = blank_r;
    key_nxt        = key_r;
    phase_nxt      = phase_r;
    found_nxt      = found_r;
    value_nxt      = value_r;
    saw_cr_nxt     = saw_cr_r;
    hdr_done_nxt   = hdr_done_r;
    hdr_bytes_nxt  = hdr_bytes_r;
    body_rem_nxt   = body_rem_r;
    res_valid      = 1'b0;
    res            = '0;
    bad            = 1'b0;
    clear          = 1'b0;

    if (step) begin
      if (hdr_done_r) begin
        body_rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          res_valid         = 1'b1;
          res.status        = ST_OK;
          res.header_length = hdr_bytes_r;
          res.body_length   = FIELD_W'(value_r);
          clear             = 1'b1;
        end
      end else if (cnt_inc > {1'b0, lim}) begin
        res_valid  = 1'b1;
        res.status = ST_OVERFLOW;
        clear      = 1'b1;
      end else begin
        byte_count_nxt = cnt_inc[FIELD_W-1:0];

        if (!found_r) begin
          if (key_r != KEY_W'(KEY_LEN) && lc == key_char(key_r)) begin
            key_nxt = key_r + KEY_W'(1);
          end else begin
            key_nxt = (lc == key_char('0)) ? KEY_W'(1) : '0;
          end
          if (key_nxt == KEY_W'(KEY_LEN)) begin
            found_nxt = 1'b1;
            phase_nxt = PH_LEAD;
            value_nxt = '0;
          end
        end else if (phase_r != PH_IDLE) begin
          if (saw_cr_r) begin
            if (data == CH_LF) begin
              phase_nxt  = PH_IDLE;
              saw_cr_nxt = 1'b0;
            end else begin
              bad = 1'b1;
            end
          end else if (data == CH_CR) begin
            if (phase_r == PH_LEAD) bad = 1'b1;
            else saw_cr_nxt = 1'b1;
          end else if (is_digit) begin
            if (phase_r == PH_TRAIL || nv > MAX_NV) begin
              bad = 1'b1;
            end else begin
              value_nxt = nv[VAL_W-1:0];
              phase_nxt = PH_DIGIT;
            end
          end else if (data <= CH_SPACE) begin
            if (phase_r == PH_DIGIT) phase_nxt = PH_TRAIL;
          end else begin
            bad = 1'b1;
          end
        end

        if (bad) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_LEN;
          clear      = 1'b1;
        end else if (data == CH_CR) begin
          blank_nxt = (blank_r == BL_CRLF) ? BL_CRLFCR : BL_CR;
        end else if (data == CH_LF && (blank_r == BL_CR || blank_r == BL_CRLFCR)) begin
          if (blank_r == BL_CRLFCR) begin
            // End of header; the value can no longer change here.
            if (total > SUM_W'(lim)) begin
              res_valid  = 1'b1;
              res.status = ST_OVERFLOW;
              clear      = 1'b1;
            end else if (value_r == '0) begin
              res_valid         = 1'b1;
              res.status        = ST_OK;
              res.header_length = cnt_inc[FIELD_W-1:0];
              clear             = 1'b1;
            end else begin
              blank_nxt     = BL_NONE;
              hdr_done_nxt  = 1'b1;
              hdr_bytes_nxt = cnt_inc[FIELD_W-1:0];
              body_rem_nxt  = value_r;
            end
          end else begin
            blank_nxt = BL_CRLF;
          end
        end else begin
          blank_nxt = BL_NONE;
        end
      end

      if (clear) begin
        byte_count_nxt = '0;
        blank_nxt      = BL_NONE;
        key_nxt        = '0;
        phase_nxt      = PH_IDLE;
        found_nxt      = 1'b0;
        value_nxt      = '0;
        saw_cr_nxt     = 1'b0;
        hdr_done_nxt   = 1'b0;
        hdr_bytes_nxt  = '0;
        body_rem_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      blank_r      <= BL_NONE;
      key_r        <= '0;
      phase_r      <= PH_IDLE;
      found_r      <= 1'b0;
      value_r      <= '0;
      saw_cr_r     <= 1'b0;
      hdr_done_r   <= 1'b0;
      hdr_bytes_r  <= '0;
      body_rem_r   <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
      blank_r      <= blank_nxt;
      key_r        <= key_nxt;
      phase_r      <= phase_nxt;
      found_r      <= found_nxt;
      value_r      <= value_nxt;
      saw_cr_r     <= saw_cr_nxt;
      hdr_done_r   <= hdr_done_nxt;
      hdr_bytes_r  <= hdr_bytes_nxt;
      body_rem_r   <= body_rem_nxt;
    end
  end

endmodule

>>> hw/rtl/hrf_out_reg.sv
// Result register of the HTTP request framer, decoupling it from the consumer.
// Depends on hrf_pkg.
module hrf_out_reg
  import hrf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  input  hrf_res_t           res,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_header_length,
  output logic [FIELD_W-1:0] out_body_length
);

  logic     out_valid_r, out_valid_nxt;
  hrf_res_t res_r;

  assign can_load      = !out_valid_r || out_ready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_r.status;
  assign out_header_length = res_r.header_length;
  assign out_body_length   = res_r.body_length;

endmodule

>>> hw/rtl/http_request_framer.sv
// HTTP request framer. Bytes of a request stream enter one per beat on the
// input channel. The block finds the end of each header (CR LF CR LF), picks
// up the first "Content-Length:" in the header (letter case ignored), parses
// its decimal value with blanks allowed around the digits, counts that many
// body bytes and then delivers one result beat: status 0 with the header and
// body lengths. A malformed value gives status 2, and a message larger than
// the max_message_size register (clamped to MAX_BYTES) gives status 1; both
// carry zero lengths and drop the partial message, so the next byte starts a
// new one. Beats that do not finish or break a message produce no result.
// One byte is accepted every clock cycle for as long as the result side keeps
// up; the rate is set by the single parser step between the input register
// and the result register. The beat that completes a message passes the input
// register and the parser, and its result is then held in the output register.
// If a result waits on the output, the byte held in the input register is
// parsed only once the output register is freed, so the input stalls then.
// No memory is used, so the block is ready right after reset.
// Register map: max_message_size at byte address 0 (bits 20:0).
// Depends on hrf_pkg, hrf_in_reg, hrf_core and hrf_out_reg.
module http_request_framer
  import hrf_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Byte stream.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_data_byte,
  // Results.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_header_length,
  output logic [FIELD_W-1:0] out_body_length,
  // Configuration.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [FIELD_W-1:0] max_size_r;
  logic               cfg_wr;
  logic               s1_valid;
  logic [7:0]         s1_byte;
  logic               can_load;
  logic               step;
  logic               res_valid;
  hrf_res_t           res;

  // The register is written in the access phase; pready never stalls.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_SIZE);
  assign prdata = (paddr[2] == REG_MAX_SIZE) ? DATA_W'(max_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= MAX_SIZE_RST;
    end else if (cfg_wr) begin
      max_size_r <= pwdata[FIELD_W-1:0];
    end
  end

  // The parser takes the held byte whenever the result register can absorb
  // whatever result that byte may produce.
  assign step = s1_valid && can_load;

  hrf_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .advance      (step),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte)
  );

  hrf_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data      (s1_byte),
    .max_size  (max_size_r),
    .res_valid (res_valid),
    .res       (res)
  );

  hrf_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res               (res),
    .can_load          (can_load),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_header_length (out_header_length),
    .out_body_length   (out_body_length)
  );

endmodule

>>> hw/rtl/hrf_checker.sv
// Port-level checks of the HTTP request framer, bound to its top level.
// Depends on hrf_pkg and http_request_framer.
module hrf_port_checks
  import hrf_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic [FIELD_W-1:0] out_header_length,
  input logic [FIELD_W-1:0] out_body_length
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_header_length) && $stable(out_body_length))
    else $error("result beat changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_OVERFLOW
      || out_status == ST_BAD_LEN))
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_header_length == '0 && out_body_length == '0)
    else $error("error result carries lengths");

  // A complete header ends in CR LF CR LF, so it has at least four bytes.
  a_header_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |-> out_header_length >= FIELD_W'(4))
    else $error("header length too short");

endmodule

bind http_request_framer hrf_port_checks u_hrf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_header_length (out_header_length),
  .out_body_length   (out_body_length)
);

>>> tb/hrf_checker.sv
// Scoreboard for the HTTP request framer: it follows every accepted byte with a
// framing model of its own and checks each result beat against the oldest one.
// Depends on hrf_pkg for the field widths, status codes and register index.
module hrf_checker
  import hrf_pkg::*;
#(
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic [FIELD_W-1:0] out_header_length,
  input  logic [FIELD_W-1:0] out_body_length,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 frames_pending
);

  localparam logic [0:KEY_LEN-1][7:0] KEY_TEXT = "content-length:";
  localparam logic [7:0] CR = 8'h0d;
  localparam logic [7:0] LF = 8'h0a;

  typedef enum logic [1:0] {VAL_NONE, VAL_LEAD, VAL_DIGITS, VAL_TRAIL} value_phase_t;
  typedef enum logic [1:0] {SEEN_NONE, SEEN_CR, SEEN_CRLF, SEEN_CRLFCR} blank_prog_t;

  logic [FIELD_W-1:0] size_limit_reg;
  int unsigned        msg_bytes;
  int unsigned        key_pos;
  int unsigned        value_num;
  int unsigned        header_len;
  int unsigned        body_left;
  value_phase_t       value_phase;
  blank_prog_t        blank_prog;
  bit                 key_seen;
  bit                 value_cr;
  bit                 in_body;
  hrf_res_t           frames_due[$];
  int                 mismatches = 0;
  int                 pending_now = 0;

  assign fail_count     = mismatches;
  assign frames_pending = pending_now;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic frame_clear();
    msg_bytes   = 0;
    key_pos     = 0;
    value_num   = 0;
    header_len  = 0;
    body_left   = 0;
    value_phase = VAL_NONE;
    blank_prog  = SEEN_NONE;
    key_seen    = 1'b0;
    value_cr    = 1'b0;
    in_body     = 1'b0;
  endtask

  // Every result, good or bad, ends the message in progress.
  task automatic frame_done(input logic [1:0] st, input int unsigned hl,
                            input int unsigned bl);
    hrf_res_t r;
    r.status        = st;
    r.header_length = hl[FIELD_W-1:0];
    r.body_length   = bl[FIELD_W-1:0];
    frames_due.push_back(r);
    frame_clear();
  endtask

  task automatic frame_byte(input logic [7:0] b);
    int unsigned lim;
    int unsigned next_num;
    logic [7:0]  lc;
    bit          bad;
    lim = (size_limit_reg > MAX_BYTES) ? MAX_BYTES : size_limit_reg;
    lc  = (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
    bad = 1'b0;
    msg_bytes++;
    if (in_body) begin
      // Body bytes are only counted; the size was checked at the header end.
      if (body_left > 0) body_left--;
      if (body_left == 0) frame_done(ST_OK, header_len, value_num);
    end else if (msg_bytes > lim) begin
      frame_done(ST_OVERFLOW, 0, 0);
    end else begin
      if (!key_seen) begin
        if (key_pos < KEY_LEN && lc == KEY_TEXT[key_pos]) key_pos++;
        else if (lc == KEY_TEXT[0]) key_pos = 1;
        else key_pos = 0;
        if (key_pos == KEY_LEN) begin
          key_seen    = 1'b1;
          value_phase = VAL_LEAD;
          value_num   = 0;
        end
      end else if (value_phase != VAL_NONE) begin
        if (value_cr) begin
          if (b == LF) begin
            value_phase = VAL_NONE;
            value_cr    = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end else if (b == CR) begin
          if (value_phase == VAL_LEAD) bad = 1'b1;
          else value_cr = 1'b1;
        end else if (b >= "0" && b <= "9") begin
          next_num = value_num * 10 + (b - "0");
          if (value_phase == VAL_TRAIL || next_num > MAX_BYTES) begin
            bad = 1'b1;
          end else begin
            value_num   = next_num;
            value_phase = VAL_DIGITS;
          end
        end else if (b <= 8'h20) begin
          if (value_phase == VAL_DIGITS) value_phase = VAL_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end

      if (bad) begin
        frame_done(ST_BAD_LEN, 0, 0);
      end else if (b == CR) begin
        if (blank_prog == SEEN_CRLF) blank_prog = SEEN_CRLFCR;
        else blank_prog = SEEN_CR;
      end else if (b == LF && blank_prog == SEEN_CRLFCR) begin
        header_len = msg_bytes;
        if (header_len + value_num > lim) begin
          frame_done(ST_OVERFLOW, 0, 0);
        end else if (value_num == 0) begin
          frame_done(ST_OK, header_len, 0);
        end else begin
          blank_prog = SEEN_NONE;
          in_body    = 1'b1;
          body_left  = value_num;
        end
      end else if (b == LF && blank_prog == SEEN_CR) begin
        blank_prog = SEEN_CRLF;
      end else begin
        blank_prog = SEEN_NONE;
      end
    end
  endtask

  always @(posedge clk) begin
    hrf_res_t want;
    if (!rst_n) begin
      frame_clear();
      size_limit_reg = MAX_SIZE_RST;
      frames_due.delete();
    end else begin
      // Results first: a beat leaving now always belongs to an older byte.
      if (out_valid && out_ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, 0);
        end else begin
          want = frames_due.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_header_length !== want.header_length)
            report_mismatch("header_length", out_header_length, want.header_length);
          if (out_body_length !== want.body_length)
            report_mismatch("body_length", out_body_length, want.body_length);
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_SIZE)
        size_limit_reg = pwdata[FIELD_W-1:0];
      if (in_valid && in_ready) frame_byte(in_data_byte);
    end
    pending_now = frames_due.size();
  end

endmodule

>>> tb/tb.sv
// Top of the HTTP request framer testbench: clock, reset, byte and register
// stimulus, random stalls and the verdict. Depends on hrf_pkg, the framer RTL
// and hrf_checker, which predicts and compares every result beat.
module tb;
  import hrf_pkg::*;

  // The watchdog counts cycles in which no beat and no register access moves.
  // The longest legal quiet stretch is the settle pause plus a register write,
  // so this bound leaves a wide margin.
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int PHASES          = 7;
  localparam int CALM_PHASE      = 5;
  localparam int BYTES_PER_PHASE = 55;

  localparam logic [7:0] CR = 8'h0d;
  localparam logic [7:0] LF = 8'h0a;

  // The size register is register 0, so it sits at byte address 0.
  localparam logic [ADDR_W-1:0] ADDR_MAX_SIZE = {REG_MAX_SIZE, 2'b00};

  // Ways in which a Content-Length value can be malformed.
  typedef enum int {
    FLAW_EMPTY, FLAW_SIGN, FLAW_GAP_DIGIT, FLAW_CR_ALONE, FLAW_STRAY, FLAW_TOO_BIG
  } length_flaw_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic [FIELD_W-1:0] out_header_length;
  logic [FIELD_W-1:0] out_body_length;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  int                 fail_count;
  int                 frames_pending;
  int                 bytes_sent = 0;
  int                 quiet_cycles = 0;
  bit                 calm = 1'b0;
  logic [7:0]         req[$];

  always #2 clk = ~clk;

  http_request_framer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_header_length (out_header_length),
    .out_body_length   (out_body_length),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  hrf_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_header_length (out_header_length),
    .out_body_length   (out_body_length),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .fail_count        (fail_count),
    .frames_pending    (frames_pending)
  );

  // The result side stalls in about one cycle of five, except during the calm
  // phase, in which it takes every result at once.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 21);
  end

  // Watchdog: a hung handshake ends the run instead of letting it spin.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Sends one byte beat. It is entered at a falling edge and returns at the
  // falling edge after the beat was taken. Valid is left high on return, so
  // back-to-back beats never lower and raise it within one time step; an idle
  // gap lowers it here instead, and settle() lowers it when the stream pauses.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_request();
    foreach (req[i]) send_byte(req[i]);
    req.delete();
  endtask

  // Holds the sender until every predicted result has arrived, then lets the
  // two-stage pipeline drain bytes that produce no result of their own. Only
  // after this may the size register change.
  task automatic settle();
    in_valid <= 1'b0;
    wait (frames_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: a setup cycle, then an access cycle held until pready.
  task automatic write_max_size(input logic [FIELD_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_SIZE;
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Appends text; with mix_case set, each letter flips to upper case at random.
  task automatic add_text(input string s, input bit mix_case);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (mix_case && c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c & 8'hdf;
      req.push_back(c);
    end
  endtask

  task automatic add_crlf();
    req.push_back(CR);
    req.push_back(LF);
  endtask

  task automatic add_junk(input int unsigned n, input int unsigned lo, input int unsigned hi);
    repeat (n) req.push_back(8'($urandom_range(lo, hi)));
  endtask

  // Any control byte or space except CR is a blank inside the value, a lone
  // LF and a NUL included.
  task automatic add_blanks(input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      c = 8'($urandom_range(0, 32));
      if (c == CR) c = " ";
      req.push_back(c);
    end
  endtask

  task automatic add_header_line();
    add_junk($urandom_range(1, 6), "a", "z");
    add_text(": ", 0);
    add_junk($urandom_range(1, 8), 33, 255);
    add_crlf();
  endtask

  task automatic build_head();
    add_text("GET /", 0);
    add_junk($urandom_range(0, 4), "a", "z");
    add_text(" HTTP/1.1", 0);
    add_crlf();
    repeat ($urandom_range(0, 2)) add_header_line();
  endtask

  // A well-formed request: most carry a Content-Length with blanks around the
  // digits and a short body; a few carry bodies of a few hundred bytes.
  task automatic build_good();
    int unsigned body_len;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) body_len = 0;
    else if (pick < 95) body_len = $urandom_range(1, 30);
    else body_len = $urandom_range(100, 300);
    build_head();
    if ($urandom_range(99) < 75) begin
      add_text("content-length:", 1);
      add_blanks($urandom_range(0, 2));
      if ($urandom_range(3) == 0) add_text("0", 0);
      add_text($sformatf("%0d", body_len), 0);
      add_blanks($urandom_range(0, 2));
      add_crlf();
    end else begin
      body_len = 0;
    end
    repeat ($urandom_range(0, 2)) add_header_line();
    add_crlf();
    add_junk(body_len, 0, 255);
  endtask

  // A request whose Content-Length breaks at some byte; whatever follows that
  // byte is the start of the next message.
  task automatic build_broken();
    length_flaw_t flaw;
    flaw = length_flaw_t'($urandom_range(FLAW_TOO_BIG));
    build_head();
    add_text("content-length:", 1);
    add_blanks($urandom_range(0, 1));
    case (flaw)
      FLAW_EMPTY: begin
        req.push_back(CR);
      end
      FLAW_SIGN: begin
        if ($urandom_range(1) == 1) add_text("-", 0);
        else add_text("+", 0);
        add_text($sformatf("%0d", $urandom_range(0, 99)), 0);
      end
      FLAW_GAP_DIGIT: begin
        add_text($sformatf("%0d", $urandom_range(0, 99)), 0);
        add_blanks($urandom_range(1, 2));
        add_text($sformatf("%0d", $urandom_range(0, 9)), 0);
      end
      FLAW_CR_ALONE: begin
        add_text($sformatf("%0d", $urandom_range(0, 99)), 0);
        req.push_back(CR);
        add_junk(1, LF + 1, 255);
      end
      FLAW_STRAY: begin
        add_text($sformatf("%0d", $urandom_range(0, 99)), 0);
        add_junk(1, "9" + 1, 255);
      end
      default: begin
        add_text($sformatf("%0d", $urandom_range(MAX_BYTES_DEF + 1, 9999999)), 0);
      end
    endcase
  endtask

  // Short hand-written messages covering each corner of the value parser.
  task automatic run_directed();
    // A lone blank line is a complete four-byte header without a body.
    add_crlf();
    add_crlf();
    // Mixed-case keyword, a tab and a NUL ahead of the digits, a lone LF and
    // a space after them, then a three-byte body with extreme byte values.
    add_text("cONTENT-lENGTH:", 0);
    req.push_back(8'h09);
    req.push_back(8'h00);
    add_text("3", 0);
    req.push_back(LF);
    req.push_back(" ");
    add_crlf();
    add_crlf();
    req.push_back(8'h00);
    req.push_back(8'h7f);
    req.push_back(8'hff);
    // A header without any keyword completes with a zero body length.
    add_text("GET / HTTP/1.1", 0);
    add_crlf();
    add_text("Host: a", 0);
    add_crlf();
    add_crlf();
    // A value of zero, written with a leading zero.
    add_text("Content-Length: 00", 0);
    add_crlf();
    add_crlf();
    // Only the first keyword counts; the second one is just a header line.
    add_text("content-length:2", 0);
    add_crlf();
    add_text("CONTENT-LENGTH:x", 0);
    add_crlf();
    add_crlf();
    add_text("ok", 0);
    // The largest legal value cannot fit beside any header, so the size
    // check at the end of the header fires.
    add_text("content-length:1048576", 0);
    add_crlf();
    add_crlf();
    // Malformed values, each message ending right at the offending byte.
    add_text("content-length:", 0);
    req.push_back(CR);
    add_text("content-length:-7", 0);
    add_text("content-length:+7", 0);
    add_text("content-length: 1 2", 0);
    add_text("content-length:1", 0);
    req.push_back(CR);
    add_text("X", 0);
    add_text("content-length:!", 0);
    add_text("content-length:1048577", 0);
    send_request();
    settle();
  endtask

  initial begin
    logic [FIELD_W-1:0] phase_limit [PHASES];
    int                 target;
    int                 pick;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The directed messages run at the reset value of the size register.
    run_directed();

    // Each phase sets a new size limit: zero, where every byte overflows; one;
    // small limits that most requests exceed; a value above the clamp; the
    // maximum; and a random middle value.
    phase_limit = '{21'd0, 21'd1, 21'd24, 21'd64, 21'h1fffff, 21'd1048576,
                    FIELD_W'($urandom_range(100, 2000))};
    for (int p = 0; p < PHASES; p++) begin
      write_max_size(phase_limit[p]);
      calm   = (p == CALM_PHASE);
      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 72) build_good();
        else if (pick < 88) build_broken();
        else add_junk($urandom_range(1, 16), 0, 255);
        send_request();
        // Now and then the sender waits for every result before going on.
        if ($urandom_range(15) == 0) settle();
      end
      settle();
    end

    if (fail_count == 0 && frames_pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/hrf_pkg.sv
hw/rtl/hrf_in_reg.sv
hw/rtl/hrf_core.sv
hw/rtl/hrf_out_reg.sv
hw/rtl/http_request_framer.sv
hw/rtl/hrf_checker.sv
tb/hrf_checker.sv
tb/tb.sv
